// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, entry type, operation and status codes shared by the queue files.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int HANDLE_BITS   = 16;
  localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [HANDLE_BITS-1:0]   hnd;
  } entry_t;

  // Per-beat commands broadcast to every cell, already qualified
  typedef struct packed {
    logic ins;
    logic rem;
    logic pop;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: holds an entry, shifts in from either side.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     req,
  input  wire logic       occ,
  input  wire entry_t     left_data,
  input  wire logic       left_take,
  input  wire logic       left_seen,
  input  wire entry_t     right_data,
  output entry_t          data,
  output logic            take,
  output logic            seen
);

  // At or past the insertion point: slot free or holding a later priority
  assign take = !occ || (data.prio > req.prio);
  // At or past the first slot whose priority matches the remove request
  assign seen = left_seen || (occ && (data.prio == req.prio));

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_take) begin
        data <= left_data;
      end else if (take) begin
        data <= req;
      end
    end else if (ctrl.rem) begin
      if (seen) begin
        data <= right_data;
      end
    end else if (ctrl.pop) begin
      data <= right_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sorted_priority_task_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority task queue
// Bounded queue of task handles kept in ascending priority order.
// ----------------------------------------------------------------------------
// The queue takes one operation beat per clock (insert, remove by priority,
// pop head, clear) and returns exactly one result beat for each, in the
// cycle after the beat is accepted. Entries live in a row of CAPACITY cells with
// the head in cell 0; every cell compares its own priority against the
// request in the same cycle and shifts toward or away from the head, so the
// clock period is set by the match chain that ripples from cell 0 to the
// last cell on a remove. The result sits in an output register, so a new
// operation is accepted while a finished result waits, and in_stall only
// rises when that register is full and the consumer is stalling. Equal
// priorities keep arrival order, an insert into a full queue reports full,
// a pop of an empty queue reports empty with a zero handle, and a remove
// that finds no matching priority reports not found; none of these change
// the contents. No clearing pass is needed after reset: the fill count
// alone says which cells hold entries.
// ----------------------------------------------------------------------------
module sorted_priority_task_queue_top
  import spq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               op,
  input  wire logic [PRIORITY_BITS-1:0] priority_req,
  input  wire logic [HANDLE_BITS-1:0]   handle,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [HANDLE_BITS-1:0]        out_handle,
  output logic [1:0]                    status,
  output logic [COUNT_BITS-1:0]         entry_count,
  output logic                          is_empty
);

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;

  entry_t     req;
  cell_ctrl_t ctrl;
  op_t        op_code;
  status_t    st_next;
  logic       accept;
  logic       full;
  logic       found;
  logic [HANDLE_BITS-1:0] hnd_next;

  entry_t               cell_data [CAPACITY];
  logic [CAPACITY-1:0]  cell_occ;
  logic [CAPACITY-1:0]  cell_take;
  logic [CAPACITY-1:0]  cell_seen;

  // Hold the input only while a result waits and the consumer stalls
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign req.prio = priority_req;
  assign req.hnd  = handle;
  assign op_code  = op_t'(op);
  assign full     = (count == COUNT_BITS'(CAPACITY));
  // The match chain leaves the last cell set only if some entry matched
  assign found    = cell_seen[CAPACITY-1];

  // Cell chain: each cell talks only to its two neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_d;
    entry_t right_d;
    logic   left_t;
    logic   left_s;

    assign cell_occ[g] = (COUNT_BITS'(g) < count);

    if (g == 0) begin : g_head
      assign left_d = req;
      assign left_t = 1'b0;
      assign left_s = 1'b0;
    end else begin : g_body
      assign left_d = cell_data[g-1];
      assign left_t = cell_take[g-1];
      assign left_s = cell_seen[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = cell_data[g];
    end else begin : g_inner
      assign right_d = cell_data[g+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .req        (req),
      .occ        (cell_occ[g]),
      .left_data  (left_d),
      .left_take  (left_t),
      .left_seen  (left_s),
      .right_data (right_d),
      .data       (cell_data[g]),
      .take       (cell_take[g]),
      .seen       (cell_seen[g])
    );
  end

  // Decode the beat: qualify cell commands, work out status and new count
  always_comb begin
    ctrl       = '0;
    st_next    = ST_OK;
    count_next = count;
    hnd_next   = '0;
    unique case (op_code)
      OP_INSERT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          ctrl.ins   = accept;
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          ctrl.rem   = accept;
          count_next = count - 1'b1;
        end else begin
          st_next = ST_NOTFOUND;
        end
      end
      OP_POP: begin
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else begin
          ctrl.pop   = accept;
          count_next = count - 1'b1;
          hnd_next   = cell_data[0].hnd;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  // Fill count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted beat, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      out_handle  <= hnd_next;
      status      <= st_next;
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level properties of the queue results, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [HANDLE_BITS-1:0]   out_handle,
  input wire logic [1:0]               status,
  input wire logic [COUNT_BITS-1:0]    entry_count,
  input wire logic                     is_empty
);

  // A stalled result beat stays up and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_handle) && $stable(status)
      && $stable(entry_count) && $stable(is_empty))
    else $error("result beat changed while stalled");

  // Empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  // A full report only comes with a full queue
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (entry_count == COUNT_BITS'(CAPACITY)))
    else $error("full status with queue not full");

  // An empty report only comes with an empty queue and a zero handle
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> is_empty && (out_handle == '0))
    else $error("empty status with entries or handle");

  // A nonzero handle is only returned by a successful pop
  a_handle_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_handle != '0) |-> (status == ST_OK))
    else $error("handle returned with error status");

endmodule

bind sorted_priority_task_queue_top spq_checker u_spq_checker (.*);
`default_nettype wire
